// File: design/trl_pkg.sv
// Shared constants and codes for the transmit retry ladder with backoff.
// Used by trl_backoff and tx_retry_ladder_backoff; depends on nothing else.
package trl_pkg;

  // Ladder depth and the width of the ladder position, which counts one past the last slot.
  localparam int NUM_SLOTS_DEF = 4;
  localparam int SLOT_POS_W    = 3;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int LIMIT_W  = 5;
  localparam int TRIES_W  = 5;
  localparam int TOTAL_W  = 7;
  localparam int WIN_W    = 16;
  localparam int RND_W    = 16;
  localparam int ACK_W    = 16;
  localparam int CW_MIN_W = 10;
  localparam int CW_MAX_W = 15;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_CW_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CW_MAX = 1'b1;

  // Reset values of the contention window registers.
  localparam logic [CW_MIN_W-1:0] CW_MIN_RST = 10'd16;
  localparam logic [CW_MAX_W-1:0] CW_MAX_RST = 15'd1024;

  // Saturation points.
  localparam logic [TRIES_W-1:0] TRIES_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [ACK_W-1:0]   ACK_MAX   = '1;

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ATTEMPT = 2'd1;
  localparam logic [OP_W-1:0] OP_DONE    = 2'd2;

endpackage

// File: design/trl_backoff.sv
// Contention window update and backoff value for one transmit attempt.
// Depends on trl_pkg for widths.
module trl_backoff (
  input  logic                          first_try,
  input  logic [trl_pkg::WIN_W-1:0]     window,
  input  logic [trl_pkg::CW_MIN_W-1:0]  cw_min,
  input  logic [trl_pkg::CW_MAX_W-1:0]  cw_max,
  input  logic [trl_pkg::RND_W-1:0]     rnd,
  output logic [trl_pkg::WIN_W-1:0]     window_nxt,
  output logic [trl_pkg::WIN_W-1:0]     backoff
);

  logic [trl_pkg::WIN_W-1:0] win_dbl;
  logic [trl_pkg::WIN_W-1:0] win_cap;
  logic [trl_pkg::WIN_W-1:0] cw_max_ext;
  logic [trl_pkg::WIN_W-1:0] rnd_masked;
  logic [trl_pkg::WIN_W-1:0] rnd_x10;

  // Double the window within 16 bits and cap it at cw_max; a first try restarts at cw_min.
  assign win_dbl    = {window[trl_pkg::WIN_W-2:0], 1'b0};
  assign cw_max_ext = trl_pkg::WIN_W'(cw_max);
  assign win_cap    = (win_dbl > cw_max_ext) ? cw_max_ext : win_dbl;
  assign window_nxt = first_try ? trl_pkg::WIN_W'(cw_min) : win_cap;

  // Window plus ten times the masked random value, modulo 2^16; ten is eight plus two.
  assign rnd_masked = rnd & (window_nxt - trl_pkg::WIN_W'(1));
  assign rnd_x10    = {rnd_masked[trl_pkg::WIN_W-4:0], 3'b000}
                    + {rnd_masked[trl_pkg::WIN_W-2:0], 1'b0};
  assign backoff    = window_nxt + rnd_x10;

endmodule

// File: design/tx_retry_ladder_backoff.sv
// Top level of the transmit retry ladder controller with exponential backoff.
// Depends on trl_pkg and instantiates trl_backoff.
//
//  Port group | Direction | Contents
//  -----------+-----------+-------------------------------------------------
//  in_        | slave     | tuser: operation; tdata: limits, no_ack, random
//  out_       | master    | tuser: give_up; tdata: slot, retry, backoff, ...
//  cfg_       | write     | cw_min (index 0), cw_max (index 1)
//
// Every transaction is handled in the cycle it is accepted: the frame state is
// updated at that edge and the result is held in the output register.
// One item per cycle is sustained; the input is stalled only while a result
// waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous) clears all frame state and loads the register
// defaults; there is no clearing pass.
module tx_retry_ladder_backoff #(
  parameter int NUM_SLOTS = trl_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tuser: [1:0] operation
  input  logic [trl_pkg::OP_W-1:0]         in_tuser,
  // tdata: [4:0] limit_slot0, [9:5] limit_slot1, [14:10] limit_slot2,
  // [19:15] limit_slot3, [20] no_ack, [36:21] random, [39:37] zero
  input  logic [trl_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tuser: [0] give_up
  output logic                             out_tuser,
  // tdata: [1:0] slot, [2] retry_flag, [18:3] backoff, [23:19] tries_slot0,
  // [28:24] tries_slot1, [33:29] tries_slot2, [38:34] tries_slot3,
  // [54:39] ack_failures, [55] zero
  output logic [trl_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [trl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = trl_pkg::LIMIT_W;
  localparam int TW = trl_pkg::TRIES_W;
  localparam int SW = trl_pkg::SLOT_POS_W;

  // Configuration and frame state.
  logic [trl_pkg::CW_MIN_W-1:0] cw_min_r;
  logic [trl_pkg::CW_MAX_W-1:0] cw_max_r;
  logic [SW-1:0]                ladder_r, ladder_nxt;
  logic [TW-1:0]                tries_r   [NUM_SLOTS];
  logic [TW-1:0]                tries_nxt [NUM_SLOTS];
  logic [LW-1:0]                limit_r   [NUM_SLOTS];
  logic [trl_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [trl_pkg::WIN_W-1:0]    window_r, window_nxt;
  logic                         no_ack_r, no_ack_nxt;
  logic [trl_pkg::ACK_W-1:0]    ack_r, ack_nxt;

  // Output register.
  logic                          out_valid_r;
  logic                          out_user_r;
  logic [trl_pkg::OUT_DATA_W-1:0] out_data_r;

  // Decoded input fields.
  logic [trl_pkg::OP_W-1:0]  op;
  logic [LW-1:0]             lim_in [4];
  logic                      no_ack_in;
  logic [trl_pkg::RND_W-1:0] rnd_in;

  // Attempt datapath.
  logic                      accept;
  logic [TW-1:0]             cur_tries;
  logic [LW-1:0]             cur_limit;
  logic [SW-1:0]             ladder_adv;
  logic                      exhausted;
  logic                      first_try;
  logic [trl_pkg::WIN_W-1:0] win_calc;
  logic [trl_pkg::WIN_W-1:0] backoff_calc;
  logic [TW-1:0]             tries_rep [4];

  // Result fields.
  logic                      res_give_up;
  logic [1:0]                res_slot;
  logic                      res_retry;
  logic [trl_pkg::WIN_W-1:0] res_backoff;
  logic                      res_report;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  assign op        = in_tuser;
  assign lim_in[0] = in_tdata[4:0];
  assign lim_in[1] = in_tdata[9:5];
  assign lim_in[2] = in_tdata[14:10];
  assign lim_in[3] = in_tdata[19:15];
  assign no_ack_in = in_tdata[20];
  assign rnd_in    = in_tdata[36:21];

  // Count and limit of the current ladder slot; none when past the end.
  always_comb begin
    cur_tries = '0;
    cur_limit = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (ladder_r == SW'(i)) begin
        cur_tries = tries_r[i];
        cur_limit = limit_r[i];
      end
    end
  end

  // Step at most one slot when the current slot's limit is reached.
  always_comb begin
    ladder_adv = ladder_r;
    if ((ladder_r < SW'(NUM_SLOTS)) && (cur_tries >= cur_limit)) begin
      ladder_adv = ladder_r + SW'(1);
    end
  end

  assign exhausted = (ladder_adv >= SW'(NUM_SLOTS));
  assign first_try = (tries_r[0] == '0);

  trl_backoff u_backoff (
    .first_try  (first_try),
    .window     (window_r),
    .cw_min     (cw_min_r),
    .cw_max     (cw_max_r),
    .rnd        (rnd_in),
    .window_nxt (win_calc),
    .backoff    (backoff_calc)
  );

  // Try counts as reported; slots beyond the ladder read as zero.
  generate
    for (genvar g = 0; g < 4; g++) begin : g_rep
      if (g < NUM_SLOTS) begin : g_used
        assign tries_rep[g] = tries_r[g];
      end else begin : g_unused
        assign tries_rep[g] = '0;
      end
    end
  endgenerate

  // Next frame state and result fields for the operation presented.
  always_comb begin
    ladder_nxt  = ladder_r;
    tries_nxt   = tries_r;
    total_nxt   = total_r;
    window_nxt  = window_r;
    no_ack_nxt  = no_ack_r;
    ack_nxt     = ack_r;
    res_give_up = 1'b0;
    res_slot    = '0;
    res_retry   = 1'b0;
    res_backoff = '0;
    res_report  = 1'b0;
    case (op)
      trl_pkg::OP_START: begin
        no_ack_nxt = no_ack_in;
        ladder_nxt = '0;
        total_nxt  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) tries_nxt[i] = '0;
      end
      trl_pkg::OP_ATTEMPT: begin
        if (exhausted) begin
          res_give_up = 1'b1;
          res_report  = 1'b1;
          ladder_nxt  = '0;
          total_nxt   = '0;
          for (int i = 0; i < NUM_SLOTS; i++) tries_nxt[i] = '0;
        end else begin
          ladder_nxt  = ladder_adv;
          window_nxt  = win_calc;
          res_slot    = ladder_adv[1:0];
          res_retry   = !first_try;
          res_backoff = backoff_calc;
          if ((total_r != '0) && !no_ack_r && (ack_r != trl_pkg::ACK_MAX)) begin
            ack_nxt = ack_r + trl_pkg::ACK_W'(1);
          end
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if ((ladder_adv == SW'(i)) && (tries_r[i] != trl_pkg::TRIES_MAX)) begin
              tries_nxt[i] = tries_r[i] + TW'(1);
            end
          end
          if (total_r != trl_pkg::TOTAL_MAX) begin
            total_nxt = total_r + trl_pkg::TOTAL_W'(1);
          end
        end
      end
      trl_pkg::OP_DONE: begin
        res_report = 1'b1;
        ladder_nxt = '0;
        total_nxt  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) tries_nxt[i] = '0;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_min_r <= trl_pkg::CW_MIN_RST;
      cw_max_r <= trl_pkg::CW_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trl_pkg::CFG_CW_MIN: cw_min_r <= cfg_data[trl_pkg::CW_MIN_W-1:0];
        trl_pkg::CFG_CW_MAX: cw_max_r <= cfg_data[trl_pkg::CW_MAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ladder_r <= '0;
      total_r  <= '0;
      window_r <= trl_pkg::WIN_W'(trl_pkg::CW_MIN_RST);
      no_ack_r <= 1'b0;
      ack_r    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tries_r[i] <= '0;
        limit_r[i] <= '0;
      end
    end else if (accept) begin
      ladder_r <= ladder_nxt;
      total_r  <= total_nxt;
      window_r <= window_nxt;
      no_ack_r <= no_ack_nxt;
      ack_r    <= ack_nxt;
      tries_r  <= tries_nxt;
      if (op == trl_pkg::OP_START) begin
        for (int i = 0; i < NUM_SLOTS; i++) limit_r[i] <= lim_in[i];
      end
    end
  end

  // Output register: loaded on accept, released when the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_user_r <= res_give_up;
      out_data_r <= {1'b0, ack_nxt,
                     res_report ? tries_rep[3] : TW'(0),
                     res_report ? tries_rep[2] : TW'(0),
                     res_report ? tries_rep[1] : TW'(0),
                     res_report ? tries_rep[0] : TW'(0),
                     res_backoff, res_retry, res_slot};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for tx_retry_ladder_backoff: a directed part, then random
// frame sequences under several window settings, idling patterns and long stalls.
// Depends on trl_pkg and the tx_retry_ladder_backoff RTL only.
`timescale 1ns / 100ps

import trl_pkg::*;

// Holds a private model of the retry ladder and the queue of results it predicts.
class retry_scoreboard;

  typedef struct {
    bit                 give_up;
    bit [1:0]           slot;
    bit                 retry;
    bit [WIN_W-1:0]     backoff;
    bit [TRIES_W-1:0]   tries [4];
    bit [ACK_W-1:0]     ack_failures;
  } ladder_result_t;

  localparam int LADDER_DEPTH = NUM_SLOTS_DEF;

  ladder_result_t predicted_q [$];

  // Register copies and per-frame ladder state.
  bit [CW_MIN_W-1:0]   cw_min;
  bit [CW_MAX_W-1:0]   cw_max;
  bit [SLOT_POS_W-1:0] slot_pos;
  bit [TRIES_W-1:0]    slot_tries [4];
  bit [TOTAL_W-1:0]    total_tries;
  bit [WIN_W-1:0]      window;
  bit [LIMIT_W-1:0]    slot_limits [4];
  bit                  frame_no_ack;
  bit [ACK_W-1:0]      ack_fail_count;

  int errors;
  int results_checked;
  int give_ups;
  int retries;
  int zero_window_tries;

  function new();
    cw_min         = CW_MIN_RST;
    cw_max         = CW_MAX_RST;
    window         = WIN_W'(CW_MIN_RST);
    frame_no_ack   = 1'b0;
    ack_fail_count = '0;
    foreach (slot_limits[i]) slot_limits[i] = '0;
    clear_frame();
  endfunction

  function void clear_frame();
    slot_pos    = '0;
    total_tries = '0;
    foreach (slot_tries[i]) slot_tries[i] = '0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_CW_MIN) cw_min = value[CW_MIN_W-1:0];
    else                   cw_max = value[CW_MAX_W-1:0];
  endfunction

  // Works out the result of one accepted input transaction.
  function void note_input(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
    ladder_result_t    res;
    bit                first;
    bit [WIN_W-1:0]    doubled;
    bit [WIN_W-1:0]    mask;
    bit [RND_W-1:0]    rnd;

    res = '{default: '0};
    rnd = data[36:21];
    case (op)
      OP_START: begin
        slot_limits[0] = data[4:0];
        slot_limits[1] = data[9:5];
        slot_limits[2] = data[14:10];
        slot_limits[3] = data[19:15];
        frame_no_ack   = data[20];
        clear_frame();
      end
      OP_ATTEMPT: begin
        // At most one step along the ladder per attempt.
        if (slot_pos < LADDER_DEPTH && slot_tries[slot_pos] >= slot_limits[slot_pos])
          slot_pos++;
        if (slot_pos >= LADDER_DEPTH) begin
          res.give_up = 1'b1;
          res.tries   = slot_tries;
          give_ups++;
          clear_frame();
        end else begin
          first = (slot_tries[0] == '0);
          if (first) begin
            window = WIN_W'(cw_min);
          end else begin
            doubled = {window[WIN_W-2:0], 1'b0};
            window  = (doubled > cw_max) ? WIN_W'(cw_max) : doubled;
            retries++;
          end
          if (window == '0) zero_window_tries++;
          mask        = window - 1'b1;
          res.slot    = slot_pos[1:0];
          res.retry   = !first;
          res.backoff = WIN_W'(window + 10 * (rnd & mask));
          if (total_tries != '0 && !frame_no_ack && ack_fail_count != ACK_MAX)
            ack_fail_count++;
          if (slot_tries[slot_pos] != TRIES_MAX) slot_tries[slot_pos]++;
          if (total_tries != TOTAL_MAX) total_tries++;
        end
      end
      OP_DONE: begin
        res.tries = slot_tries;
        clear_frame();
      end
      default: ;
    endcase
    res.ack_failures = ack_fail_count;
    predicted_q.push_back(res);
  endfunction

  function void compare_field(string name, int unsigned want, logic [15:0] got);
    if (got !== 16'(want)) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compares one accepted result with the oldest prediction.
  function void check_result(logic give_up, logic [OUT_DATA_W-1:0] data);
    ladder_result_t want;

    if (predicted_q.size() == 0) begin
      $error("result transaction with no prediction waiting: give_up %b data %h",
             give_up, data);
      errors++;
      return;
    end
    want = predicted_q.pop_front();
    results_checked++;
    compare_field("give_up",      want.give_up,      {15'b0, give_up});
    compare_field("slot",         want.slot,         {14'b0, data[1:0]});
    compare_field("retry_flag",   want.retry,        {15'b0, data[2]});
    compare_field("backoff",      want.backoff,      data[18:3]);
    compare_field("tries_slot0",  want.tries[0],     {11'b0, data[23:19]});
    compare_field("tries_slot1",  want.tries[1],     {11'b0, data[28:24]});
    compare_field("tries_slot2",  want.tries[2],     {11'b0, data[33:29]});
    compare_field("tries_slot3",  want.tries[3],     {11'b0, data[38:34]});
    compare_field("ack_failures", want.ack_failures, data[54:39]);
  endfunction

endclass

module tb_top;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 80;
  localparam int RANDOM_ITEMS = 310;
  localparam int SOAK_ITEMS   = 24;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OP_W-1:0]        in_tuser = '0;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   out_tuser;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  retry_scoreboard ladder_sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int items_sent    = 0;
  int settings_used = 1;

  tx_retry_ladder_backoff DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: checks each accepted result and drives out_tready.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) ladder_sb.check_result(out_tuser, out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [4:0] l0, input logic [4:0] l1, input logic [4:0] l2,
    input logic [4:0] l3, input logic no_ack, input logic [15:0] rnd
  );
    return {3'b000, rnd, no_ack, l3, l2, l1, l0};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_item();
    return pack_item(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     1'($urandom), 16'($urandom));
  endfunction

  // Offers one input transaction, with random gaps before it, and waits for acceptance.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    ladder_sb.note_input(op, data);
    items_sent++;
  endtask

  task automatic send_attempt(input logic [15:0] rnd);
    send_item(OP_ATTEMPT, pack_item(5'($urandom), 5'($urandom), 5'($urandom),
                                    5'($urandom), 1'($urandom), rnd));
  endtask

  // Lowers valid and waits until every predicted result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ladder_sb.predicted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both window registers on consecutive edges.
  task automatic configure(input logic [CFG_DATA_W-1:0] min_val,
                           input logic [CFG_DATA_W-1:0] max_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CW_MIN;
    cfg_data  <= min_val;
    @(posedge clk);
    ladder_sb.write_register(CFG_CW_MIN, min_val);
    cfg_index <= CFG_CW_MAX;
    cfg_data  <= max_val;
    @(posedge clk);
    ladder_sb.write_register(CFG_CW_MAX, max_val);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [4:0] random_limit();
    return ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
  endfunction

  // Mostly whole frames (start, attempts, usually done), with some stray items between.
  task automatic run_frames(input int count);
    int          stop_at;
    int          ladder_len;
    int          attempts;
    logic [4:0]  lim [4];
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        ladder_len = 0;
        foreach (lim[i]) begin
          lim[i]     = random_limit();
          ladder_len += (lim[i] == 0) ? 1 : lim[i];
        end
        send_item(OP_START, pack_item(lim[0], lim[1], lim[2], lim[3],
                                      ($urandom_range(3) == 0), 16'($urandom)));
        attempts = $urandom_range(1, ladder_len + 2);
        repeat (attempts) send_attempt(16'($urandom));
        if ($urandom_range(99) < 85) send_item(OP_DONE, random_item());
      end else begin
        send_item(2'($urandom_range(3)), random_item());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset window settings.
    send_attempt(16'hffff);
    send_item(OP_START, pack_item(5'd0, 5'd0, 5'd0, 5'd0, 1'b0, 16'h0000));
    send_attempt(16'hffff);
    send_attempt(16'h0000);
    send_attempt(16'haaaa);
    send_attempt(16'h5555);
    send_attempt(16'hffff);
    send_item(OP_DONE, pack_item(5'd0, 5'd0, 5'd0, 5'd0, 1'b0, 16'h0000));
    send_item(OP_UNKNOWN, pack_item(5'h1f, 5'h1f, 5'h1f, 5'h1f, 1'b1, 16'hffff));
    send_item(OP_START, pack_item(5'd31, 5'd31, 5'd31, 5'd31, 1'b1, 16'hffff));
    repeat (3) send_attempt(16'hffff);
    send_item(OP_DONE, pack_item(5'h1f, 5'h1f, 5'h1f, 5'h1f, 1'b1, 16'hffff));
    send_item(OP_START, pack_item(5'd2, 5'd0, 5'd1, 5'd3, 1'b0, 16'hffff));
    repeat (4) send_attempt(16'($urandom));
    send_item(OP_UNKNOWN, random_item());
    repeat (2) send_attempt(16'($urandom));
    send_item(OP_DONE, random_item());
    drain();

    // Random phases; the frame state runs on across each register change.
    send_idle_pct = 19;
    recv_idle_pct = 45;
    configure(15'd1, 15'd1);
    run_frames(RANDOM_ITEMS);
    drain();
    configure(15'd1023, 15'd32767);
    hold_req = 1'b1;
    run_frames(RANDOM_ITEMS);
    drain();

    send_idle_pct = 45;
    recv_idle_pct = 19;
    // Upper bits beyond cw_min's width are dropped, leaving a zero window.
    configure(15'h7c00, 15'd32767);
    run_frames(RANDOM_ITEMS);
    drain();
    configure(15'($urandom_range(1, 1023)), 15'($urandom_range(1, 32767)));
    run_frames(RANDOM_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(15'h7fff, 15'd1000);
    hold_req = 1'b1;
    run_frames(RANDOM_ITEMS);
    drain();
    configure(15'd5, 15'd300);
    run_frames(RANDOM_ITEMS);
    drain();

    // A run of retries on a full-length ladder, with an ack expected on each.
    configure(15'(CW_MIN_RST), 15'(CW_MAX_RST));
    send_item(OP_START, pack_item(5'd31, 5'd31, 5'd31, 5'd31, 1'b0, 16'h0000));
    repeat (SOAK_ITEMS) send_attempt(16'($urandom));
    send_item(OP_DONE, random_item());
    drain();

    $display("Checked %0d results over %0d window settings: %0d give-ups, %0d retries,",
             ladder_sb.results_checked, settings_used, ladder_sb.give_ups, ladder_sb.retries);
    $display("%0d attempts with a zero window, ack failure count ended at %0d.",
             ladder_sb.zero_window_tries, ladder_sb.ack_fail_count);
    if (ladder_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
